FILE: rtl/sct_pkg.sv
package sct_pkg;

   // Token length saturates here; the result field is 8 bits wide
   localparam int MAX_TOKEN_LEN = 255;
   localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

   // Result kind codes
   localparam logic [2:0] KIND_KEYWORD = 3'd0;
   localparam logic [2:0] KIND_IDENT   = 3'd1;
   localparam logic [2:0] KIND_NUMBER  = 3'd2;
   localparam logic [2:0] KIND_OPER    = 3'd3;
   localparam logic [2:0] KIND_DELIM   = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN = 3'd5;

   // Result queue depth; a request is taken while two slots are free
   localparam int RSP_DEPTH = 4;

   // Characters with special meaning
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_EQ  = "=";
   localparam logic [7:0] CH_GT  = ">";
   localparam logic [7:0] CH_LT  = "<";
   localparam logic [7:0] CH_NOT = "!";

   // Keyword table: while, if, else, for, int, float, return, void
   localparam int KW_COUNT = 8;
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL},
      '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"f", "o", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"f", "l", "o", "a", "t", CH_NUL, CH_NUL, CH_NUL},
      '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
      '{"v", "o", "i", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd2, 3'd4, 3'd3, 3'd3, 3'd5, 3'd6, 3'd4
   };

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] keyword_index;
      logic [7:0] token_length;
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       last_of_run;
   } rsp_type;

   // Results of one request, handed from the lexer to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } step_out_type;

   // Keywords whose character at position pos equals c
   function automatic logic [KW_COUNT-1:0] kw_hits(logic [7:0] c, logic [7:0] pos);
      logic [KW_COUNT-1:0] hits;
      hits = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         hits[k] = (pos < {5'd0, KW_LEN[k]}) && (KW_TEXT[k][pos[2:0]] == c);
      end
      return hits;
   endfunction

endpackage

FILE: rtl/sct_step.sv
module sct_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sct_pkg::req_type      req_data,
   output sct_pkg::step_out_type step_out
);
   import sct_pkg::*;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_WORD,
      CLS_NUM,
      CLS_OP
   } tok_class_type;

   tok_class_type       cls_ff, cls_in;
   logic [7:0]          len_ff, len_in;
   logic [KW_COUNT-1:0] km_ff, km_in;
   logic [7:0]          first_ff, first_in;

   logic [7:0] ch;
   logic       is_alpha, is_digit, is_space, is_pend_op, is_op, is_delim;

   // Build a plain result
   function automatic rsp_type mk_token(logic [2:0] kind, logic [7:0] len,
                                        logic [7:0] first, logic [7:0] second);
      rsp_type t;
      t               = '0;
      t.kind          = kind;
      t.token_length  = len;
      t.first_char    = first;
      t.second_char   = second;
      return t;
   endfunction

   // Result for an open token being closed
   function automatic rsp_type flush_token(tok_class_type cls, logic [7:0] len,
                                           logic [KW_COUNT-1:0] km, logic [7:0] first);
      rsp_type t;
      t = '0;
      unique case (cls)
         CLS_WORD: begin
            t = mk_token(KIND_IDENT, len, first, CH_NUL);
            for (int k = 0; k < KW_COUNT; k++) begin
               if (km[k] && len == {5'd0, KW_LEN[k]}) begin
                  t.kind          = KIND_KEYWORD;
                  t.keyword_index = 3'(k);
               end
            end
         end
         CLS_NUM:  t = mk_token(KIND_NUMBER, len, first, CH_NUL);
         CLS_OP:   t = mk_token(KIND_OPER, 8'd1, first, CH_NUL);
         default:  t = '0;
      endcase
      return t;
   endfunction

   // Character classes
   assign ch         = req_data.char_in;
   assign is_alpha   = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
   assign is_digit   = (ch >= "0" && ch <= "9");
   assign is_space   = (ch == " ") || (ch >= 8'd9 && ch <= 8'd13);
   assign is_pend_op = (ch == CH_GT) || (ch == CH_LT) || (ch == CH_EQ) || (ch == CH_NOT);
   assign is_op      = is_pend_op || (ch == "+") || (ch == "-") || (ch == "*")
                       || (ch == "/") || (ch == "%");
   assign is_delim   = (ch == "(") || (ch == ")") || (ch == ";") || (ch == "{")
                       || (ch == "}") || (ch == "[") || (ch == "]") || (ch == ",");

   // One request: next token state and up to two results
   always_comb begin
      rsp_type    tok;
      logic       emit;
      logic [1:0] n;
      rsp_type    r0, r1;

      cls_in   = cls_ff;
      len_in   = len_ff;
      km_in    = km_ff;
      first_in = first_ff;
      n        = 2'd0;
      r0       = '0;
      r1       = '0;
      tok      = '0;
      emit     = 1'b0;

      if (cls_ff == CLS_WORD && (is_alpha || is_digit)) begin
         km_in  = km_ff & kw_hits(ch, len_ff);
         len_in = (len_ff < LEN_CAP) ? len_ff + 8'd1 : len_ff;
      end else if (cls_ff == CLS_NUM && is_digit) begin
         len_in = (len_ff < LEN_CAP) ? len_ff + 8'd1 : len_ff;
      end else if (cls_ff == CLS_OP && ch == CH_EQ) begin
         r0       = mk_token(KIND_OPER, 8'd2, first_ff, CH_EQ);
         n        = 2'd1;
         cls_in   = CLS_NONE;
         len_in   = 8'd0;
         first_in = CH_NUL;
      end else begin
         // close the open token, then take the character afresh
         if (cls_ff != CLS_NONE) begin
            r0 = flush_token(cls_ff, len_ff, km_ff, first_ff);
            n  = 2'd1;
         end
         cls_in   = CLS_NONE;
         len_in   = 8'd0;
         km_in    = '1;
         first_in = CH_NUL;
         if (is_space) begin
            emit = 1'b0;
         end else if (is_alpha) begin
            cls_in   = CLS_WORD;
            first_in = ch;
            km_in    = kw_hits(ch, 8'd0);
            len_in   = 8'd1;
         end else if (is_digit) begin
            cls_in   = CLS_NUM;
            first_in = ch;
            len_in   = 8'd1;
         end else if (is_pend_op) begin
            cls_in   = CLS_OP;
            first_in = ch;
            len_in   = 8'd1;
         end else if (is_op) begin
            tok  = mk_token(KIND_OPER, 8'd1, ch, CH_NUL);
            emit = 1'b1;
         end else if (is_delim) begin
            tok  = mk_token(KIND_DELIM, 8'd1, ch, CH_NUL);
            emit = 1'b1;
         end else begin
            tok  = mk_token(KIND_UNKNOWN, 8'd1, ch, CH_NUL);
            emit = 1'b1;
         end
      end

      // line end closes whatever is still open
      if (req_data.line_end && cls_in != CLS_NONE) begin
         tok      = flush_token(cls_in, len_in, km_in, first_in);
         emit     = 1'b1;
         cls_in   = CLS_NONE;
         len_in   = 8'd0;
         km_in    = '1;
         first_in = CH_NUL;
      end

      if (emit) begin
         if (n == 2'd0) begin
            r0 = tok;
         end else begin
            r1 = tok;
         end
         n = n + 2'd1;
      end

      if (n == 2'd1) begin
         r0.last_of_run = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last_of_run = 1'b1;
      end

      step_out.count = n;
      step_out.slot0 = r0;
      step_out.slot1 = r1;
   end

   // Open token state
   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff   <= CLS_NONE;
         len_ff   <= 8'd0;
         km_ff    <= '1;
         first_ff <= CH_NUL;
      end else if (advance) begin
         cls_ff   <= cls_in;
         len_ff   <= len_in;
         km_ff    <= km_in;
         first_ff <= first_in;
      end
   end

endmodule

FILE: rtl/sct_rsp_queue.sv
module sct_rsp_queue #(
   parameter int DEPTH = sct_pkg::RSP_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sct_pkg::step_out_type push_data,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sct_pkg::rsp_type      rsp_payload
);
   import sct_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   push_n;
   logic               pop;

   assign pop         = rsp_valid && rsp_ready;
   assign push_n      = push ? CNT_W'(push_data.count) : '0;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entries_ff[rd_ptr_ff];
   // two free slots cover the worst case of one request
   assign room        = (count_ff <= CNT_W'(DEPTH - 2));

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + (pop ? PTR_W'(1) : PTR_W'(0));
      count_in  = count_ff + push_n - (pop ? CNT_W'(1) : CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (push && push_data.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data.slot0;
      end
      if (push && push_data.count == 2'd2) begin
         entries_ff[wr_ptr_ff + PTR_W'(1)] <= push_data.slot1;
      end
   end

endmodule

FILE: rtl/source_code_tokenizer.sv
// Streaming source-code tokenizer.
// Request channel (req_valid/req_ready/req_payload): one character byte per
// request, with line_end set on the last character of a line.
// Result channel (rsp_valid/rsp_ready/rsp_payload): one result per token, with
// kind, keyword index, length, first and second character; last_of_run marks
// the final result a request caused. A request gives zero, one or two results.
// A taken request is held in the input register, which feeds the lexer stage;
// its results are written into the result queue and offered from there.
// Throughput: one request per cycle while the result queue has room; the
// lexer's token state is registered. Results leave at one per cycle while
// rsp_ready is high, so the two results of one request leave in turn.
// A four-entry result queue parts the two sides: requests keep flowing while
// the receiver stalls, until fewer than two queue slots are free, then
// req_ready drops and the request in the lexer stage waits.
// Reset (synchronous) empties the queue and the input stage and closes any
// open token.
module source_code_tokenizer #(
   parameter int RSP_DEPTH = sct_pkg::RSP_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sct_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sct_pkg::rsp_type rsp_payload
);
   import sct_pkg::*;

   logic         in_valid_ff;
   req_type      in_data_ff;
   logic         room;
   logic         advance;
   step_out_type step_out;

   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   sct_step u_step (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_data (in_data_ff),
      .step_out (step_out)
   );

   sct_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (advance),
      .push_data   (step_out),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/sct_checker.sv
module sct_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sct_pkg::rsp_type rsp_payload
);
   import sct_pkg::*;

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Keyword index and second character only where the kind allows them
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.kind <= KIND_UNKNOWN)
                    && (rsp_payload.kind == KIND_KEYWORD || rsp_payload.keyword_index == 3'd0)
                    && (rsp_payload.kind == KIND_OPER || rsp_payload.second_char == CH_NUL))
      else $error("result fields do not fit its kind");

   // Two-character operators end in '=' and have length two
   a_oper_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.second_char != CH_NUL
         |-> rsp_payload.second_char == CH_EQ && rsp_payload.token_length == 8'd2)
      else $error("bad two-character operator");

   // Every token holds at least one character
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.token_length != 8'd0)
      else $error("empty token");

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
